@@ design/ppp_pkg.sv @@
// Shared constants, register indexes and the configuration type of the
// pinhole point projection unit. No dependencies.
package ppp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CFG_WIDTH       = 32;
    localparam int SIZE_WIDTH      = 15;
    localparam int PIX_WIDTH       = 16;
    localparam int QUO_BITS        = PIX_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FOCAL_X       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FOCAL_Y       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_HEIGHT  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALLOW_OUTSIDE = 3'd6;

    localparam logic [CFG_WIDTH-1:0]  RST_FOCAL_X      = 32'd65536000;
    localparam logic [CFG_WIDTH-1:0]  RST_FOCAL_Y      = 32'd65536000;
    localparam logic [CFG_WIDTH-1:0]  RST_CENTER_X     = 32'd41943040;
    localparam logic [CFG_WIDTH-1:0]  RST_CENTER_Y     = 32'd23592960;
    localparam logic [SIZE_WIDTH-1:0] RST_IMAGE_WIDTH  = 15'd1280;
    localparam logic [SIZE_WIDTH-1:0] RST_IMAGE_HEIGHT = 15'd720;

    typedef struct packed {
        logic [CFG_WIDTH-1:0]  focal_x;
        logic [CFG_WIDTH-1:0]  focal_y;
        logic [CFG_WIDTH-1:0]  center_x;
        logic [CFG_WIDTH-1:0]  center_y;
        logic [SIZE_WIDTH-1:0] image_width;
        logic [SIZE_WIDTH-1:0] image_height;
        logic                  allow_outside;
    } cfg_t;

endpackage

@@ design/ppp_point_if.sv @@
// Valid/ready channel carrying one camera-frame point.
// Depends on nothing; width set by COORD_WIDTH.
interface ppp_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] depth_x;
    logic signed [COORD_WIDTH-1:0] lateral_y;
    logic signed [COORD_WIDTH-1:0] vertical_z;

    modport source (output valid, depth_x, lateral_y, vertical_z, input ready);
    modport sink   (input valid, depth_x, lateral_y, vertical_z, output ready);
endinterface

@@ design/ppp_pixel_if.sv @@
// Valid/ready channel carrying one projected pixel result.
// Depends on nothing.
interface ppp_pixel_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;

    modport source (output valid, hit, pixel_col, pixel_row, input ready);
    modport sink   (input valid, hit, pixel_col, pixel_row, output ready);
endinterface

@@ design/ppp_cfg_regs.sv @@
// Configuration register file of the projection unit, written by index.
// Depends on ppp_pkg.
module ppp_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ppp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_wr_index,
    input  logic [ppp_pkg::CFG_WIDTH-1:0]        cfg_wr_data,
    output ppp_pkg::cfg_t                        cfg
);
    import ppp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                CFG_FOCAL_X:       cfg_next.focal_x       = cfg_wr_data;
                CFG_FOCAL_Y:       cfg_next.focal_y       = cfg_wr_data;
                CFG_CENTER_X:      cfg_next.center_x      = cfg_wr_data;
                CFG_CENTER_Y:      cfg_next.center_y      = cfg_wr_data;
                CFG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_wr_data[SIZE_WIDTH-1:0];
                CFG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_wr_data[SIZE_WIDTH-1:0];
                CFG_ALLOW_OUTSIDE: cfg_next.allow_outside = cfg_wr_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x       <= RST_FOCAL_X;
            cfg_reg.focal_y       <= RST_FOCAL_Y;
            cfg_reg.center_x      <= RST_CENTER_X;
            cfg_reg.center_y      <= RST_CENTER_Y;
            cfg_reg.image_width   <= RST_IMAGE_WIDTH;
            cfg_reg.image_height  <= RST_IMAGE_HEIGHT;
            cfg_reg.allow_outside <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ppp_axis.sv @@
// One projection axis: multiply, combine, saturation check and a
// radix-2 restoring divider with one quotient bit per stage. Depends on ppp_pkg.
module ppp_axis #(
    parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ppp_pkg::CFG_WIDTH-1:0]   center,
    input  logic [ppp_pkg::CFG_WIDTH-1:0]   focal,
    input  logic [COORD_WIDTH-2:0]          depth_mag,
    input  logic                            lat_neg,
    input  logic [COORD_WIDTH-1:0]          lat_mag,
    output logic [ppp_pkg::PIX_WIDTH-1:0]   pixel
);
    import ppp_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int QB   = QUO_BITS;
    localparam int P1W  = CFG_WIDTH + W - 1;
    localparam int P2W  = CFG_WIDTH + W;
    localparam int NW   = CFG_WIDTH + W + 1;
    localparam int MW   = NW - 1 - FRAC_BITS;
    localparam int CMPW = (MW > W - 1 + QB) ? MW : W - 1 + QB;

    // Stage A: products
    logic [P1W-1:0] t1_reg;
    logic [P2W-1:0] t2_reg;
    logic           neg_a_reg;
    logic [W-2:0]   dvs_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= center * depth_mag;
            t2_reg    <= lat_mag * focal;
            neg_a_reg <= lat_neg;
            dvs_a_reg <= depth_mag;
        end
    end

    // Stage B: signed numerator folded to a magnitude
    logic [NW-1:0]   num_next;
    logic [NW-2:0]   mag_reg;
    logic            sgn_b_reg;
    logic [W-2:0]    dvs_b_reg;

    always_comb
    begin
        if (neg_a_reg)
            num_next = NW'(t1_reg) + NW'(t2_reg);
        else
            num_next = NW'(t1_reg) - NW'(t2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_b_reg <= num_next[NW-1];
            mag_reg   <= num_next[NW-1] ? ~num_next[NW-2:0] : num_next[NW-2:0];
            dvs_b_reg <= dvs_a_reg;
        end
    end

    // Stage C: drop fraction, saturation check, first partial remainder
    logic [W-2:0]  rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] quo_reg [0:QB];
    logic [W-2:0]  dvs_reg [0:QB];
    logic          sat_reg [0:QB];
    logic          sgn_reg [0:QB];

    logic [MW-1:0]   shf_next;
    logic [CMPW-1:0] shf_ext;
    logic [CMPW-1:0] lim_ext;

    assign shf_next = mag_reg[NW-2:FRAC_BITS];
    assign shf_ext  = CMPW'(shf_next);
    assign lim_ext  = CMPW'({dvs_b_reg, {QB{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= shf_ext[QB +: (W - 1)];
            low_reg[0] <= shf_next[QB-1:0];
            quo_reg[0] <= '0;
            dvs_reg[0] <= dvs_b_reg;
            sat_reg[0] <= (shf_ext >= lim_ext);
            sgn_reg[0] <= sgn_b_reg;
        end
    end

    // Stages D: one quotient bit each
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [W-1:0] trial_next;
        logic [W-1:0] diff_next;
        logic         ge_next;

        assign trial_next = {rem_reg[k], low_reg[k][QB-1]};
        assign diff_next  = trial_next - {1'b0, dvs_reg[k]};
        assign ge_next    = (trial_next >= {1'b0, dvs_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge_next ? diff_next[W-2:0] : trial_next[W-2:0];
                low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QB-2:0], ge_next};
                dvs_reg[k+1] <= dvs_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                sgn_reg[k+1] <= sgn_reg[k];
            end
        end
    end

    logic [PIX_WIDTH-1:0] unsigned_pix;

    assign unsigned_pix = sat_reg[QB] ? {1'b0, {QB{1'b1}}} : {1'b0, quo_reg[QB]};
    assign pixel        = sgn_reg[QB] ? ~unsigned_pix : unsigned_pix;

endmodule

@@ design/pinhole_point_projection_unit.sv @@
// Pinhole point projection unit: streams camera-frame points in and returns
// one pixel result per point, in order. Depends on ppp_pkg, ppp_point_if,
// ppp_pixel_if, ppp_cfg_regs and ppp_axis.
//
// Accepts one point every cycle while the output is not stalled. Each point passes
// through an input stage, a multiply stage, a combine stage, a saturation stage,
// 15 divider stages (one quotient bit each, both axes in parallel) and an output
// register with the image bounds check. A stall at the output freezes the
// whole pipeline; nothing is dropped or repeated. Write configuration only
// while no point is in flight.
module pinhole_point_projection_unit #(
    parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ppp_pkg::CFG_INDEX_WIDTH-1:0] cfg_wr_index,
    input  logic [ppp_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
    ppp_point_if.sink                           point,
    ppp_pixel_if.source                         pixel
);
    import ppp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int LAT = 3 + QUO_BITS;

    cfg_t cfg;
    logic en;

    ppp_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    logic out_vld_reg;

    assign en          = !out_vld_reg || pixel.ready;
    assign point.ready = en;

    // Input stage: split signs
    logic         vld_s1_reg;
    logic         bad_s1_reg;
    logic [W-2:0] xm_s1_reg;
    logic         yneg_s1_reg;
    logic [W-1:0] ym_s1_reg;
    logic         zneg_s1_reg;
    logic [W-1:0] zm_s1_reg;

    logic         bad_next;
    logic [W-1:0] ym_next;
    logic [W-1:0] zm_next;

    assign bad_next = point.depth_x[W-1] || (point.depth_x == '0);
    assign ym_next  = point.lateral_y[W-1] ? (~point.lateral_y + 1'b1) : point.lateral_y;
    assign zm_next  = point.vertical_z[W-1] ? (~point.vertical_z + 1'b1) : point.vertical_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s1_reg <= 1'b0;
        else if (en)
            vld_s1_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_s1_reg  <= bad_next;
            xm_s1_reg   <= point.depth_x[W-2:0];
            yneg_s1_reg <= point.lateral_y[W-1];
            ym_s1_reg   <= ym_next;
            zneg_s1_reg <= point.vertical_z[W-1];
            zm_s1_reg   <= zm_next;
        end
    end

    // Valid and depth flags alongside the axis pipelines
    logic [LAT-1:0] vld_pipe_reg;
    logic [LAT-1:0] bad_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_pipe_reg <= '0;
        else if (en)
            vld_pipe_reg <= {vld_pipe_reg[LAT-2:0], vld_s1_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            bad_pipe_reg <= {bad_pipe_reg[LAT-2:0], bad_s1_reg};
    end

    logic [PIX_WIDTH-1:0] col_res;
    logic [PIX_WIDTH-1:0] row_res;

    ppp_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_axis_col (
        .clk       (clk),
        .en        (en),
        .center    (cfg.center_x),
        .focal     (cfg.focal_x),
        .depth_mag (xm_s1_reg),
        .lat_neg   (yneg_s1_reg),
        .lat_mag   (ym_s1_reg),
        .pixel     (col_res)
    );

    ppp_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_axis_row (
        .clk       (clk),
        .en        (en),
        .center    (cfg.center_y),
        .focal     (cfg.focal_y),
        .depth_mag (xm_s1_reg),
        .lat_neg   (zneg_s1_reg),
        .lat_mag   (zm_s1_reg),
        .pixel     (row_res)
    );

    // Output stage: bounds check and result register
    logic inside_next;
    logic hit_next;
    logic hit_reg;
    logic [PIX_WIDTH-1:0] col_reg;
    logic [PIX_WIDTH-1:0] row_reg;

    assign inside_next = !col_res[PIX_WIDTH-1] && (col_res[SIZE_WIDTH-1:0] < cfg.image_width)
                      && !row_res[PIX_WIDTH-1] && (row_res[SIZE_WIDTH-1:0] < cfg.image_height);
    assign hit_next    = !bad_pipe_reg[LAT-1] && (cfg.allow_outside || inside_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_pipe_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            col_reg <= hit_next ? col_res : '0;
            row_reg <= hit_next ? row_res : '0;
        end
    end

    assign pixel.valid     = out_vld_reg;
    assign pixel.hit       = hit_reg;
    assign pixel.pixel_col = col_reg;
    assign pixel.pixel_row = row_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !hit_reg |-> col_reg == '0 && row_reg == '0)
        else $error("miss result carries nonzero pixel");

    a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && hit_reg && !cfg.allow_outside
        |-> !col_reg[PIX_WIDTH-1] && col_reg[SIZE_WIDTH-1:0] < cfg.image_width
            && !row_reg[PIX_WIDTH-1] && row_reg[SIZE_WIDTH-1:0] < cfg.image_height)
        else $error("hit reported outside the image");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_pipe_reg) && $stable(vld_s1_reg))
        else $error("pipeline advanced during a stall");

    a_bad_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_pipe_reg[LAT-1] && bad_pipe_reg[LAT-1] |=> out_vld_reg && !hit_reg)
        else $error("point behind the camera produced a hit");

endmodule
